>>> hdl/tmr_pkg.sv
// ----------------------------------------------------------------------------
// Total momentum removal package
// Shared constants, field widths, operation codes and the saturation helper.
// ----------------------------------------------------------------------------
package tmr_pkg;

	localparam int MAX_PARTICLES_DEF = 1024;
	localparam int MASS_W            = 16;
	localparam int VEL_W             = 32;
	localparam int IDX_W             = 10;
	localparam int SUM_W             = 64;
	localparam int PROD_W            = MASS_W + 1 + VEL_W;
	localparam int IN_DATA_W         = 112;
	localparam int OUT_DATA_W        = 112;
	localparam int REC_W             = MASS_W + 3 * VEL_W;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	typedef struct packed {
		logic idle;
	} back_status_t;

	function automatic logic [VEL_W-1:0] sat_sub(input logic [VEL_W-1:0] v,
		input logic [SUM_W-1:0] d);
		logic signed [SUM_W:0] r;
		r = $signed({{(SUM_W - VEL_W + 1){v[VEL_W-1]}}, v}) - $signed({d[SUM_W-1], d});
		if (r > $signed({{(SUM_W - VEL_W + 2){1'b0}}, {(VEL_W - 1){1'b1}}})) begin
			sat_sub = {1'b0, {(VEL_W - 1){1'b1}}};
		end else if (r < $signed({{(SUM_W - VEL_W + 2){1'b1}}, {(VEL_W - 1){1'b0}}})) begin
			sat_sub = {1'b1, {(VEL_W - 1){1'b0}}};
		end else begin
			sat_sub = r[VEL_W-1:0];
		end
	endfunction

endpackage

>>> hdl/total_momentum_removal.sv
// ----------------------------------------------------------------------------
// Total momentum removal
// Stores particles, sums their momentum and emits drift-corrected velocities.
//
// Channel  Dir  Handshake               Payload
// s_axis   in   tvalid/tready           tuser: operation; tdata: mass, vel x/y/z
// m_axis   out  tvalid/tready           tdata: index, new vel x/y/z; tlast: last
//
// A load stores the particle and registers its momentum products, which are then added to the sums.
// An emit runs the correction divides, and the first emit of a run also the share
// divides before them, on three serial dividers shared between both divides.
// Reset clears control state and the momentum sums; the particle store is never cleared.
// A registered output stage lets the next emit start while a result waits.
// ----------------------------------------------------------------------------
module total_momentum_removal #(
	parameter int MAX_PARTICLES = tmr_pkg::MAX_PARTICLES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// particle_mass[15:0], vel_x[47:16], vel_y[79:48], vel_z[111:80]
	input  logic [tmr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// operation[0]
	input  logic [0:0]                     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// particle_index[9:0], new_vel_x[41:10], new_vel_y[73:42], new_vel_z[105:74]
	output logic [tmr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast
);
	import tmr_pkg::*;

	localparam int AW = $clog2(MAX_PARTICLES);
	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int JOB_W = 3 * SUM_W + CW + AW + 2;

	back_status_t     back_status;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	logic [JOB_W-1:0] q_wdata;
	logic [JOB_W-1:0] q_rdata;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [REC_W-1:0] mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [REC_W-1:0] mem_rdata;

	tmr_front #(.MAX_PARTICLES(MAX_PARTICLES)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.back_status   (back_status),
		.q_full        (q_full),
		.q_empty       (q_empty),
		.q_push        (q_push),
		.q_wdata       (q_wdata),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata)
	);

	tmr_queue #(.WIDTH(JOB_W)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	tmr_ram #(.WIDTH(REC_W), .DEPTH(MAX_PARTICLES)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tmr_back #(.MAX_PARTICLES(MAX_PARTICLES)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_rdata       (q_rdata),
		.q_pop         (q_pop),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.back_status   (back_status),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

>>> hdl/tmr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/tmr_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Short register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module tmr_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	import tmr_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    fill_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				fill_q <= CW'(fill_q + 1'b1);
			end else if (pop && !push) begin
				fill_q <= CW'(fill_q - 1'b1);
			end
		end
	end

	assign rdata = entry_q[rd_ptr_q];
	assign full  = (fill_q == CW'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);

endmodule

>>> hdl/tmr_div.sv
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module tmr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tmr_pkg::SUM_W-1:0] num,
	input  logic [tmr_pkg::SUM_W-1:0] den,
	output logic                      done,
	output logic [tmr_pkg::SUM_W-1:0] quot
);
	import tmr_pkg::*;

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] mag_q;
	logic [SUM_W-1:0] den_q;
	logic [SUM_W-1:0] rem_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [SUM_W:0]   rem_sh;
	logic             q_bit;
	logic [SUM_W-1:0] q_clamp;

	assign rem_sh = {rem_q, mag_q[SUM_W-1]};
	assign q_bit  = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[SUM_W-1] ? SUM_W'(-num) : num;
			den_q <= den;
			rem_q <= '0;
			neg_q <= num[SUM_W-1];
		end else if (run_q) begin
			rem_q <= q_bit ? SUM_W'(rem_sh - {1'b0, den_q}) : rem_sh[SUM_W-1:0];
			mag_q <= {mag_q[SUM_W-2:0], q_bit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(SUM_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (den_q == '0) begin
			q_clamp = '0;
		end else if (mag_q[SUM_W-1]) begin
			q_clamp = {1'b0, {(SUM_W - 1){1'b1}}};
		end else begin
			q_clamp = mag_q;
		end
	end

	assign quot = neg_q ? SUM_W'(-q_clamp) : q_clamp;
	assign done = done_q;

endmodule

>>> hdl/tmr_front.sv
// ----------------------------------------------------------------------------
// Total momentum removal front part
// Accepts items, stores particles, sums momentum and queues emit jobs.
// ----------------------------------------------------------------------------
module tmr_front #(
	parameter int MAX_PARTICLES = tmr_pkg::MAX_PARTICLES_DEF,
	localparam int AW = $clog2(MAX_PARTICLES),
	localparam int CW = $clog2(MAX_PARTICLES + 1),
	localparam int JOB_W = 3 * tmr_pkg::SUM_W + CW + AW + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [tmr_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  logic [0:0]                    s_axis_tuser,
	input  tmr_pkg::back_status_t         back_status,
	input  logic                          q_full,
	input  logic                          q_empty,
	output logic                          q_push,
	output logic [JOB_W-1:0]              q_wdata,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [tmr_pkg::REC_W-1:0]     mem_wdata
);
	import tmr_pkg::*;

	logic [CW-1:0]           count_q;
	logic [CW-1:0]           ptr_q;
	logic                    emitting_q;
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [PROD_W-1:0] prod_s1 [3];
	logic                    load_s1;
	logic                    full;
	logic                    accept;
	logic                    do_load;
	logic                    do_emit;
	logic                    is_last;
	logic [MASS_W-1:0]       mass;

	assign mass    = s_axis_tdata[MASS_W-1:0];
	assign full    = (count_q >= CW'(MAX_PARTICLES));
	assign is_last = (CW'(ptr_q + 1'b1) == count_q);

	assign s_axis_tready = !load_s1 && !q_full &&
		(s_axis_tuser[0] == OP_EMIT || emitting_q || full || (back_status.idle && q_empty));
	assign accept  = s_axis_tvalid && s_axis_tready;
	assign do_load = accept && s_axis_tuser[0] == OP_LOAD && !emitting_q && !full;
	assign do_emit = accept && s_axis_tuser[0] == OP_EMIT && count_q != '0;

	assign mem_we    = do_load;
	assign mem_waddr = count_q[AW-1:0];
	assign mem_wdata = s_axis_tdata[REC_W-1:0];

	assign q_push  = do_emit;
	assign q_wdata = {sum_q[2], sum_q[1], sum_q[0], count_q, ptr_q[AW-1:0], !emitting_q,
		is_last};

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (do_load) begin
				prod_s1[a] <= $signed({1'b0, mass}) *
					$signed(s_axis_tdata[MASS_W + a * VEL_W +: VEL_W]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ptr_q      <= '0;
			emitting_q <= 1'b0;
			load_s1    <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				sum_q[a] <= '0;
			end
		end else begin
			load_s1 <= do_load;
			if (load_s1) begin
				for (int a = 0; a < 3; a++) begin
					sum_q[a] <= sum_q[a] + SUM_W'(prod_s1[a]);
				end
			end
			if (do_load) begin
				count_q <= CW'(count_q + 1'b1);
			end
			if (do_emit) begin
				if (is_last) begin
					count_q    <= '0;
					ptr_q      <= '0;
					emitting_q <= 1'b0;
					for (int a = 0; a < 3; a++) begin
						sum_q[a] <= '0;
					end
				end else begin
					ptr_q      <= CW'(ptr_q + 1'b1);
					emitting_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> hdl/tmr_back.sv
// ----------------------------------------------------------------------------
// Total momentum removal back part
// Computes shares and corrections on three serial dividers and drives results.
// ----------------------------------------------------------------------------
module tmr_back #(
	parameter int MAX_PARTICLES = tmr_pkg::MAX_PARTICLES_DEF,
	localparam int AW = $clog2(MAX_PARTICLES),
	localparam int CW = $clog2(MAX_PARTICLES + 1),
	localparam int JOB_W = 3 * tmr_pkg::SUM_W + CW + AW + 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  logic [JOB_W-1:0]               q_rdata,
	output logic                           q_pop,
	output logic                           mem_re,
	output logic [AW-1:0]                  mem_raddr,
	input  logic [tmr_pkg::REC_W-1:0]      mem_rdata,
	output tmr_pkg::back_status_t          back_status,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [tmr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast
);
	import tmr_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_READ   = 6'b000010,
		ST_SHARE  = 6'b000100,
		ST_CSTART = 6'b001000,
		ST_CORR   = 6'b010000,
		ST_FIN    = 6'b100000
	} state_t;

	state_t state_q;

	logic [SUM_W-1:0] jsum_q [3];
	logic [CW-1:0]    jcount_q;
	logic [AW-1:0]    jindex_q;
	logic             jfirst_q;
	logic             jlast_q;
	logic [MASS_W-1:0] mass_q;
	logic [VEL_W-1:0] vel_q [3];
	logic [SUM_W-1:0] share_q [3];
	logic [SUM_W-1:0] corr_q [3];

	logic             div_start;
	logic [SUM_W-1:0] div_num [3];
	logic [SUM_W-1:0] div_den;
	logic [2:0]       div_done;
	logic [SUM_W-1:0] div_quot [3];

	logic             m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic             m_last_q;
	logic             out_free;

	assign out_free  = !m_valid_q || m_axis_tready;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign mem_re    = q_pop;
	assign mem_raddr = q_rdata[2 +: AW];
	assign back_status.idle = (state_q == ST_IDLE);

	assign div_start = (state_q == ST_READ) ? jfirst_q : (state_q == ST_CSTART);
	assign div_den   = (state_q == ST_READ) ? SUM_W'(jcount_q) : SUM_W'(mass_q);

	for (genvar a = 0; a < 3; a++) begin : g_axis
		assign div_num[a] = (state_q == ST_READ) ? jsum_q[a] : share_q[a];

		tmr_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start),
			.num    (div_num[a]),
			.den    (div_den),
			.done   (div_done[a]),
			.quot   (div_quot[a])
		);
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			jlast_q  <= q_rdata[0];
			jfirst_q <= q_rdata[1];
			jindex_q <= q_rdata[2 +: AW];
			jcount_q <= q_rdata[2 + AW +: CW];
			for (int a = 0; a < 3; a++) begin
				jsum_q[a] <= q_rdata[2 + AW + CW + a * SUM_W +: SUM_W];
			end
		end
		if (state_q == ST_READ) begin
			mass_q <= mem_rdata[MASS_W-1:0];
			for (int a = 0; a < 3; a++) begin
				vel_q[a] <= mem_rdata[MASS_W + a * VEL_W +: VEL_W];
			end
		end
		if (state_q == ST_SHARE && div_done[0]) begin
			for (int a = 0; a < 3; a++) begin
				share_q[a] <= div_quot[a];
			end
		end
		if (state_q == ST_CORR && div_done[0]) begin
			for (int a = 0; a < 3; a++) begin
				corr_q[a] <= div_quot[a];
			end
		end
		if (state_q == ST_FIN && out_free) begin
			m_data_q <= {{(OUT_DATA_W - IDX_W - 3 * VEL_W){1'b0}},
				sat_sub(vel_q[2], corr_q[2]),
				sat_sub(vel_q[1], corr_q[1]),
				sat_sub(vel_q[0], corr_q[0]),
				IDX_W'(jindex_q)};
			m_last_q <= jlast_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= jfirst_q ? ST_SHARE : ST_CSTART;
				end
				ST_SHARE: begin
					if (div_done[0]) begin
						state_q <= ST_CSTART;
					end
				end
				ST_CSTART: begin
					state_q <= ST_CORR;
				end
				ST_CORR: begin
					if (div_done[0]) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

>>> test/total_momentum_removal_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Total momentum removal testbench
// Loads sets of particles and emits their drift-corrected velocities under
// several idling patterns. An internal predictor mirrors the particle store
// and momentum sums; every emitted transaction is checked field by field.
// ----------------------------------------------------------------------------
module total_momentum_removal_tb;
	import tmr_pkg::*;

	typedef struct {
		logic [IDX_W-1:0] idx;
		logic [VEL_W-1:0] vx;
		logic [VEL_W-1:0] vy;
		logic [VEL_W-1:0] vz;
		logic             last;
	} corrected_t;

	localparam int NPART     = MAX_PARTICLES_DEF;
	localparam int WDOG_LIMIT = 20000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [0:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	logic [VEL_W-1:0]  vel_store[NPART][3];
	logic [MASS_W-1:0] mass_store[NPART];
	longint            mom_sum[3];
	longint            share[3];
	int                loaded;
	int                emit_ptr;
	bit                emitting;

	corrected_t expected_vel[$];
	int         mismatches;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         quiet_cycles;

	total_momentum_removal dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint div_toward_zero(longint num, longint den);
		longint mag;
		if (den == 0) begin
			return 0;
		end
		mag = (num < 0) ? -num : num;
		mag = mag / den;
		return (num < 0) ? -mag : mag;
	endfunction

	function automatic logic [VEL_W-1:0] corrected_axis(logic [VEL_W-1:0] v,
		logic [MASS_W-1:0] m, longint s);
		longint r;
		r = longint'($signed(v)) - div_toward_zero(s, longint'(m));
		if (r > 64'sd2147483647) begin
			r = 64'sd2147483647;
		end else if (r < -64'sd2147483648) begin
			r = -64'sd2147483648;
		end
		return r[VEL_W-1:0];
	endfunction

	function automatic void predict_transaction(logic op, logic [MASS_W-1:0] m,
		logic [VEL_W-1:0] v[3]);
		corrected_t c;
		if (op == OP_LOAD) begin
			if (emitting || loaded >= NPART) begin
				return;
			end
			mass_store[loaded] = m;
			for (int a = 0; a < 3; a++) begin
				vel_store[loaded][a] = v[a];
				mom_sum[a] += longint'(m) * longint'($signed(v[a]));
			end
			loaded++;
			return;
		end
		if (loaded == 0 || emit_ptr >= loaded) begin
			return;
		end
		if (!emitting) begin
			emitting = 1;
			for (int a = 0; a < 3; a++) begin
				share[a] = div_toward_zero(mom_sum[a], longint'(loaded));
			end
		end
		c.idx = emit_ptr[IDX_W-1:0];
		c.vx = corrected_axis(vel_store[emit_ptr][0], mass_store[emit_ptr], share[0]);
		c.vy = corrected_axis(vel_store[emit_ptr][1], mass_store[emit_ptr], share[1]);
		c.vz = corrected_axis(vel_store[emit_ptr][2], mass_store[emit_ptr], share[2]);
		c.last = (emit_ptr + 1 == loaded);
		expected_vel = {expected_vel, c};
		if (c.last) begin
			loaded = 0;
			emit_ptr = 0;
			emitting = 0;
			mom_sum = '{0, 0, 0};
			share = '{0, 0, 0};
		end else begin
			emit_ptr++;
		end
	endfunction

	task automatic send_transaction(logic op, logic [MASS_W-1:0] m,
		logic [VEL_W-1:0] vx, logic [VEL_W-1:0] vy, logic [VEL_W-1:0] vz);
		logic [VEL_W-1:0] v[3];
		v = '{vx, vy, vz};
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {vz, vy, vx, m};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		predict_transaction(op, m, v);
		@(negedge clk);
	endtask

	task automatic load_random(logic [MASS_W-1:0] m);
		send_transaction(OP_LOAD, m, $urandom, $urandom, $urandom);
	endtask

	task automatic emit_one();
		send_transaction(OP_EMIT, MASS_W'($urandom), $urandom, $urandom, $urandom);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_vel.size() != 0) begin
			@(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		corrected_t e;
		logic [VEL_W-1:0] ax, ay, az;
		if (m_axis_tvalid && m_axis_tready) begin
			ax = m_axis_tdata[41:10];
			ay = m_axis_tdata[73:42];
			az = m_axis_tdata[105:74];
			if (expected_vel.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result idx=%0d", m_axis_tdata[9:0]);
				end
			end else begin
				e = expected_vel.pop_front();
				if (e.idx !== m_axis_tdata[9:0] || e.vx !== ax || e.vy !== ay
					|| e.vz !== az || e.last !== m_axis_tlast) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp idx=%0d x=%h y=%h z=%h last=%b",
							e.idx, e.vx, e.vy, e.vz, e.last);
						$display("         got idx=%0d x=%h y=%h z=%h last=%b",
							m_axis_tdata[9:0], ax, ay, az, m_axis_tlast);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic test_directed();
		emit_one();
		send_transaction(OP_LOAD, 16'h0001, 32'h7FFFFFFF, 32'h80000000, 32'h00000000);
		send_transaction(OP_LOAD, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
		send_transaction(OP_LOAD, 16'h0000, 32'h12345678, 32'h80000000, 32'h7FFFFFFF);
		send_transaction(OP_LOAD, 16'h0100, 32'hFFFFFFFF, 32'h00000001, 32'h80000001);
		emit_one();
		load_random(16'h0001);
		emit_one();
		emit_one();
		emit_one();
		emit_one();
		wait_drained();
		send_transaction(OP_LOAD, 16'h0001, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_transaction(OP_LOAD, 16'h0001, 32'h80000000, 32'h80000000, 32'h80000000);
		send_transaction(OP_LOAD, 16'h0001, 32'h80000000, 32'h80000000, 32'h80000000);
		emit_one();
		emit_one();
		emit_one();
		emit_one();
	endtask

	task automatic test_full_store();
		for (int i = 0; i < NPART + 2; i++) begin
			load_random(MASS_W'($urandom_range(1) ? 16'hFFFF : $urandom_range(65535)));
		end
		for (int i = 0; i < 12; i++) begin
			emit_one();
		end
	endtask

	task automatic test_random(int n_items);
		int sent;
		int n;
		sent = 0;
		while (sent < n_items) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				load_random(MASS_W'($urandom_range(3) == 0 ? 16'hFFFF >> $urandom_range(15)
					: $urandom_range(65535)));
			end
			for (int i = 0; i < n + $urandom_range(2); i++) begin
				if ($urandom_range(7) == 0) begin
					load_random(MASS_W'($urandom));
					sent++;
				end
				emit_one();
			end
			sent += 2 * n;
		end
	endtask

	initial begin
		mismatches = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		loaded = 0;
		emit_ptr = 0;
		emitting = 0;
		mom_sum = '{0, 0, 0};
		share = '{0, 0, 0};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(150);
		wait_drained();
		send_idle_pct = 79;
		test_random(150);
		send_idle_pct = 0;
		recv_stall_pct = 79;
		test_random(150);
		send_idle_pct = 34;
		recv_stall_pct = 34;
		test_random(150);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(150);
		test_full_store();

		wait_drained();
		repeat (200) @(negedge clk);
		if (mismatches == 0 && expected_vel.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/tmr_pkg.sv
hdl/tmr_ram.sv
hdl/tmr_queue.sv
hdl/tmr_div.sv
hdl/tmr_front.sv
hdl/tmr_back.sv
hdl/total_momentum_removal.sv
test/total_momentum_removal_tb.sv
